@@ src/arxmc_pkg.sv @@
// constants, types and word helpers shared by the arx multiply cipher core
package arxmc_pkg;

   localparam int ROUNDS = 8;
   localparam int WORDS = 4;
   localparam int WORD_BITS = 32;
   localparam int BLOCK_BYTES = 16;
   localparam int STAGES_PER_ROUND = 3;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [WORDS-1:0][WORD_BITS-1:0] block_type;

   localparam block_type MUL_K = {
      32'hf9c1e3c7, 32'h172f4f2f, 32'h47dff15d, 32'h71e961dd
   };
   localparam block_type MUL_INV_K = {
      32'h4d82edf7, 32'hfb0a57cf, 32'h185beaf5, 32'hf6e1fe75
   };

   typedef struct packed {
      logic                   decrypt;
      logic                   tail;
      logic [BLOCK_BYTES-1:0] byte_mask;
      block_type              pad;
      block_type              word;
   } blk_type;

   function automatic word_type rotl(input word_type x, input int unsigned amt);
      rotl = (x << amt) | (x >> (WORD_BITS - amt));
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned amt);
      rotr = (x >> amt) | (x << (WORD_BITS - amt));
   endfunction

endpackage

@@ src/arxmc_round.sv @@
// one cipher round as three register stages: mix halves and word multiply, in reverse order for decrypt
module arxmc_round
   import arxmc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  blk_type up_data,
   output logic    down_valid,
   input  logic    down_ready,
   output blk_type down_data
);

   logic    [STAGES_PER_ROUND-1:0] valid_ff;
   logic    [STAGES_PER_ROUND-1:0] valid_in;
   logic    [STAGES_PER_ROUND-1:0] load;
   blk_type                        data_ff [STAGES_PER_ROUND];
   blk_type                        data_in [STAGES_PER_ROUND];

   function automatic block_type mul_words(input block_type v, input block_type k);
      block_type r;
      for (int i = 0; i < WORDS; i++) begin
         r[i] = v[i] * k[i];
      end
      mul_words = r;
   endfunction

   // encrypt: first half of mix, decrypt: inverse multiply
   function automatic block_type op_first(input blk_type b);
      block_type v;
      v = b.word;
      if (b.decrypt) begin
         v = mul_words(v, MUL_INV_K);
      end else begin
         v[0] = rotl(v[0], 13) + v[1] + v[2] + v[3];
         v[1] = rotl(v[1], 7) + v[2] + v[3] + v[0];
      end
      op_first = v;
   endfunction

   // encrypt: second half of mix, decrypt: undo words 3 and 2
   function automatic block_type op_second(input blk_type b);
      block_type v;
      v = b.word;
      if (b.decrypt) begin
         v[3] = rotr(v[3] - v[0] - v[1] - v[2], 15);
         v[2] = rotr(v[2] - v[3] - v[0] - v[1], 11);
      end else begin
         v[2] = rotl(v[2], 11) + v[3] + v[0] + v[1];
         v[3] = rotl(v[3], 15) + v[0] + v[1] + v[2];
      end
      op_second = v;
   endfunction

   // encrypt: forward multiply, decrypt: undo words 1 and 0
   function automatic block_type op_third(input blk_type b);
      block_type v;
      v = b.word;
      if (b.decrypt) begin
         v[1] = rotr(v[1] - v[2] - v[3] - v[0], 7);
         v[0] = rotr(v[0] - v[1] - v[2] - v[3], 13);
      end else begin
         v = mul_words(v, MUL_K);
      end
      op_third = v;
   endfunction

   always_comb begin
      load[2] = !valid_ff[2] || down_ready;
      load[1] = !valid_ff[1] || load[2];
      load[0] = !valid_ff[0] || load[1];
      up_ready = load[0];

      valid_in[0] = load[0] ? up_valid : valid_ff[0];
      valid_in[1] = load[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = load[2] ? valid_ff[1] : valid_ff[2];

      data_in[0] = up_data;
      data_in[0].word = op_first(up_data);
      data_in[1] = data_ff[0];
      data_in[1].word = op_second(data_ff[0]);
      data_in[2] = data_ff[1];
      data_in[2].word = op_third(data_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES_PER_ROUND; s++) begin
         if (load[s]) begin
            data_ff[s] <= data_in[s];
         end
      end
   end

   assign down_valid = valid_ff[2];
   assign down_data  = data_ff[2];

`ifndef SYNTHESIS
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !up_ready |-> (valid_ff == '1))
      else $error("round refuses a transaction with an empty stage");

   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !down_ready |=> valid_ff[2] && $stable(data_ff[2]))
      else $error("round output changed while stalled");

   a_bubble_moves: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[1] && load[2] |=> !valid_ff[2])
      else $error("round output valid without a source item");

   a_middle_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && !load[2] |=> valid_ff[1] && $stable(data_ff[1]))
      else $error("middle stage lost its item while stalled");
`endif

endmodule

@@ src/arx_multiply_block_cipher_core.sv @@
// top level of the arx multiply block cipher: padding, round pipeline, tail combine
// Keyless 128-bit ARX-multiply cipher, fully unrolled: one block enters per cycle while
// the response side is not stalled, and passes through an input register, three register
// stages per round (two mix halves and one word multiply, each stage holding one set
// of four 32-bit multipliers or add chains) and an output register. Every stage is
// elastic: a stalled result holds only the stages behind it, and empty stages keep
// filling while it waits. Encrypt with a byte count below 16 returns the zero-padded
// input XOR its encipherment, bytes past the count zero; decrypt ignores the byte
// count.
module arx_multiply_block_cipher_core
   import arxmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_in_word0,
   input  logic [31:0] req_in_word1,
   input  logic [31:0] req_in_word2,
   input  logic [31:0] req_in_word3,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_word0,
   output logic [31:0] rsp_out_word1,
   output logic [31:0] rsp_out_word2,
   output logic [31:0] rsp_out_word3
);

   logic      entry_valid_ff;
   blk_type   entry_data_ff;
   blk_type   entry_data_in;
   logic      entry_load;

   logic      chain_valid [ROUNDS+1];
   logic      chain_ready [ROUNDS+1];
   blk_type   chain_data  [ROUNDS+1];

   logic      rsp_valid_ff;
   block_type rsp_word_ff;
   block_type rsp_word_in;
   logic      rsp_load;
   block_type full_mask;

   always_comb begin
      block_type raw;
      raw = {req_in_word3, req_in_word2, req_in_word1, req_in_word0};
      entry_data_in.decrypt = req_type;
      entry_data_in.tail = !req_type && (req_byte_count < 5'(BLOCK_BYTES));
      for (int j = 0; j < BLOCK_BYTES; j++) begin
         entry_data_in.byte_mask[j] = (req_byte_count > 5'(j));
      end
      entry_data_in.word = raw;
      if (entry_data_in.tail) begin
         for (int j = 0; j < BLOCK_BYTES; j++) begin
            if (!entry_data_in.byte_mask[j]) begin
               entry_data_in.word[j/4][(j%4)*8 +: 8] = 8'h00;
            end
         end
      end
      entry_data_in.pad = entry_data_in.word;
   end

   assign entry_load = !entry_valid_ff || chain_ready[0];
   assign req_ready  = entry_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (entry_load) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_load) begin
         entry_data_ff <= entry_data_in;
      end
   end

   assign chain_valid[0] = entry_valid_ff;
   assign chain_data[0]  = entry_data_ff;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      arxmc_round u_round (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[r]),
         .up_ready   (chain_ready[r]),
         .up_data    (chain_data[r]),
         .down_valid (chain_valid[r+1]),
         .down_ready (chain_ready[r+1]),
         .down_data  (chain_data[r+1])
      );
   end

   assign rsp_load = !rsp_valid_ff || rsp_ready;
   assign chain_ready[ROUNDS] = rsp_load;

   always_comb begin
      for (int j = 0; j < BLOCK_BYTES; j++) begin
         full_mask[j/4][(j%4)*8 +: 8] = {8{chain_data[ROUNDS].byte_mask[j]}};
      end
      if (chain_data[ROUNDS].tail) begin
         rsp_word_in = (chain_data[ROUNDS].pad ^ chain_data[ROUNDS].word) & full_mask;
      end else begin
         rsp_word_in = chain_data[ROUNDS].word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= chain_valid[ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_word0 = rsp_word_ff[0];
   assign rsp_out_word1 = rsp_word_ff[1];
   assign rsp_out_word2 = rsp_word_ff[2];
   assign rsp_out_word3 = rsp_word_ff[3];

endmodule
